// ----- src/itoa_pkg.sv -----
// Package for the signed integer to decimal ASCII converter.
// Holds widths, character codes and the pipeline word type; no dependencies.
package itoa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int CHAR_W = 7;
    localparam int STEPS_PER_STAGE = 8;

    // Count the decimal digits of the largest magnitude, 2^(VALUE_BITS-1).
    function automatic int calc_digits(input int bits);
        longint unsigned m;
        int n;
        begin
            m = 64'd1 << (bits - 1);
            n = 0;
            for (int k = 0; k < 20; k++) begin
                if (m != 0) begin
                    n = n + 1;
                    m = m / 10;
                end
            end
            return (n == 0) ? 1 : n;
        end
    endfunction

    localparam int DIGITS = calc_digits(VALUE_BITS);
    localparam int BCD_W = DIGITS * 4;
    localparam int IDX_W = $clog2(DIGITS);
    localparam int N_STAGES = (VALUE_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int SHIFT_W = N_STAGES * STEPS_PER_STAGE;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    // Word moved between conversion stages.
    typedef struct packed {
        logic                neg;
        logic [SHIFT_W-1:0]  bin;
        logic [BCD_W-1:0]    bcd;
    } t_dd;

endpackage

// ----- src/itoa_if.sv -----
// Valid/ready channel interfaces for the converter's input and output.
// Depends on itoa_pkg for the field widths.
interface itoa_in_if import itoa_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface itoa_out_if import itoa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink (input valid, input char_code, input is_last, output ready);
endinterface

// ----- src/itoa_dd_stage.sv -----
// One double-dabble pipeline stage: eight add-3-and-shift steps per word.
// Depends on itoa_pkg for t_dd and the step count.
module itoa_dd_stage import itoa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_dd  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_dd  o_data
);

    logic r_valid;
    t_dd  r_data;
    t_dd  n_data;

    assign o_ready = !r_valid || i_ready;

    // For each of the STEPS_PER_STAGE steps, run the add-3 correction on every digit, then shift one binary bit in.
    always_comb begin
        logic [BCD_W-1:0]   bcd;
        logic [SHIFT_W-1:0] bin;
        bcd = i_data.bcd;
        bin = i_data.bin;
        for (int s = 0; s < STEPS_PER_STAGE; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (bcd[d*4 +: 4] >= 4'd5) begin
                    bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
                end
            end
            bcd = {bcd[BCD_W-2:0], bin[SHIFT_W-1]};
            bin = {bin[SHIFT_W-2:0], 1'b0};
        end
        n_data.neg = i_data.neg;
        n_data.bin = bin;
        n_data.bcd = bcd;
    end

    // Advance when the next stage takes the held word or the stage is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data = r_data;

endmodule

// ----- src/itoa_ser.sv -----
// Character serializer: emits sign and significant BCD digits, one per cycle while the output is ready.
// Depends on itoa_pkg and itoa_out_if.
module itoa_ser import itoa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_dd         i_data,
    itoa_out_if.source  o_out
);

    logic             r_busy;
    logic             r_sign;
    logic [IDX_W-1:0] r_idx;
    logic [BCD_W-1:0] r_digits;
    logic [IDX_W-1:0] n_idx;
    logic [3:0]       cur_digit;
    logic             cur_last;
    logic             out_fire;

    // Find the most significant nonzero digit; zero starts at digit 0.
    always_comb begin
        n_idx = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (i_data.bcd[d*4 +: 4] != 4'd0) begin
                n_idx = IDX_W'(d);
            end
        end
    end

    assign cur_digit = r_digits[r_idx*4 +: 4];
    assign cur_last = !r_sign && (r_idx == '0);
    assign out_fire = o_out.valid && o_out.ready;
    assign o_ready = !r_busy || (out_fire && cur_last);

    // Load a new number, or step through the held one as characters leave.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_busy <= 1'b1;
        end else if (out_fire && cur_last) begin
            r_busy <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_sign   <= i_data.neg;
            r_idx    <= n_idx;
            r_digits <= i_data.bcd;
        end else if (out_fire) begin
            if (r_sign) begin
                r_sign <= 1'b0;
            end else if (r_idx != '0) begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end

    assign o_out.valid = r_busy;
    assign o_out.char_code = r_sign ? CHAR_MINUS : (CHAR_ZERO + CHAR_W'(cur_digit));
    assign o_out.is_last = cur_last;

endmodule

// ----- src/signed_int_to_decimal_ascii.sv -----
// Signed integer to decimal ASCII text, one character word per output cycle.
// The first character word is offered after the input register, the N_STAGES stages and the serializer load.
// A number yields 1 to 11 character words; the serializer emits one character per
// cycle while the output is ready and loads the next number on the last one.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
// Depends on itoa_pkg, itoa_if, itoa_dd_stage and itoa_ser.
module signed_int_to_decimal_ascii import itoa_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    itoa_in_if.sink    i_in,
    itoa_out_if.source o_out
);

    logic                  r_in_valid;
    t_dd                   r_in_data;
    t_dd                   n_in_data;
    logic [VALUE_BITS-1:0] mag;
    logic [N_STAGES:0]     stage_valid;
    logic [N_STAGES:0]     stage_ready;
    t_dd                   stage_data [N_STAGES+1];

    // Form the unsigned magnitude; the most negative value maps to itself.
    always_comb begin
        mag = i_in.value[VALUE_BITS-1] ? (~i_in.value + 1'b1) : i_in.value;
        n_in_data.neg = i_in.value[VALUE_BITS-1];
        n_in_data.bin = SHIFT_W'(mag);
        n_in_data.bcd = '0;
    end

    assign i_in.ready = !r_in_valid || stage_ready[0];

    // Hold the input word until the first conversion stage takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_data <= n_in_data;
        end
    end

    assign stage_valid[0] = r_in_valid;
    assign stage_data[0] = r_in_data;

    genvar k;
    generate
        for (k = 0; k < N_STAGES; k++) begin : g_dd
            itoa_dd_stage u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (stage_valid[k]),
                .o_ready (stage_ready[k]),
                .i_data  (stage_data[k]),
                .o_valid (stage_valid[k+1]),
                .i_ready (stage_ready[k+1]),
                .o_data  (stage_data[k+1])
            );
        end
    endgenerate

    itoa_ser u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (stage_valid[N_STAGES]),
        .o_ready (stage_ready[N_STAGES]),
        .i_data  (stage_data[N_STAGES]),
        .o_out   (o_out)
    );

endmodule

// ----- dv/tb_top.sv -----
// Testbench for signed_int_to_decimal_ascii: drives signed words, checks every character word.
// Depends on itoa_pkg, itoa_if and the converter RTL.
`timescale 1ns / 100ps

module tb_top import itoa_pkg::*; ();

    typedef logic signed [VALUE_BITS-1:0] t_value;

    // Expected character words, oldest first, built from each accepted number.
    class text_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0] code;
            logic              last;
        } t_char_word;

        t_char_word pending[$];
        int         errors;
        int         numbers_seen;
        int         chars_seen;
        int         negatives_seen;

        function new();
            errors = 0;
            numbers_seen = 0;
            chars_seen = 0;
            negatives_seen = 0;
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Build the decimal text of one accepted number and queue its characters.
        function void note_number(input t_value value);
            logic [VALUE_BITS-1:0] mag;
            logic [3:0]            digits[$];
            logic                  neg;
            t_char_word            w;
            int                    k;
            neg = value[VALUE_BITS-1];
            mag = neg ? (~value + 1'b1) : value;
            do begin
                digits.push_back(4'(mag % 10));
                mag = mag / 10;
            end while (mag != 0);
            if (neg) begin
                w.code = CHAR_MINUS;
                w.last = 1'b0;
                pending.push_back(w);
                negatives_seen++;
            end
            for (k = digits.size() - 1; k >= 0; k--) begin
                w.code = CHAR_ZERO + digits[k];
                w.last = (k == 0);
                pending.push_back(w);
            end
            numbers_seen++;
        endfunction

        // Compare one accepted character word with the oldest expectation.
        task check_char(input logic [CHAR_W-1:0] code, input logic last);
            t_char_word w;
            chars_seen++;
            if (pending.size() == 0) begin
                report($sformatf("unexpected char word code=%0d last=%0b", code, last));
            end else begin
                w = pending.pop_front();
                if (code !== w.code)
                    report($sformatf("char_code got %0d want %0d", code, w.code));
                if (last !== w.last)
                    report($sformatf("is_last got %0b want %0b (code %0d)", last, w.last,
                                     w.code));
            end
        endtask

        task check_leftover();
            if (pending.size() != 0)
                report($sformatf("%0d char words never arrived", pending.size()));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;

    text_scoreboard sb;

    itoa_in_if  in_if();
    itoa_out_if out_if();

    signed_int_to_decimal_ascii uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    // Clock: 20 ns period.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the output channel hangs.
    initial begin
        #10ms;
        $display("timeout: %0d char words still expected", sb.pending.size());
        $display("FAILURE");
        $finish;
    end

    // Stall the output channel at the current phase rate.
    always @(negedge i_clk) begin
        out_if.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted character word.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_char(out_if.char_code, out_if.is_last);
    end

    // Offer one number, with random idle cycles first; return after acceptance.
    task send_number(input t_value value);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            in_if.value = t_value'($urandom);
            @(negedge i_clk);
        end
        in_if.valid = 1'b1;
        in_if.value = value;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        sb.note_number(value);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every expected character word has come or the wait limit runs out.
    task drain();
        int waited;
        waited = 0;
        in_if.valid = 1'b0;
        while (sb.pending.size() != 0 && waited < 50000) begin
            @(negedge i_clk);
            waited++;
        end
    endtask

    // Pick a number: raw bit patterns, a chosen digit count, or a decimal edge.
    function automatic t_value random_value();
        int unsigned lo;
        int unsigned hi;
        int unsigned mag;
        int          n;
        int          sel;
        logic        neg;
        sel = $urandom_range(99);
        neg = 1'($urandom_range(1));
        if (sel < 40)
            return t_value'($urandom);
        if (sel < 80) begin
            n = $urandom_range(10, 1);
            lo = 1;
            for (int k = 1; k < n; k++) lo = lo * 10;
            hi = (n == 10) ? (neg ? 32'd2147483648 : 32'd2147483647) : lo * 10 - 1;
            if (n == 1) lo = 0;
            mag = $urandom_range(hi, lo);
        end else begin
            n = $urandom_range(9);
            mag = 1;
            for (int k = 0; k < n; k++) mag = mag * 10;
            mag = mag + $urandom_range(2) - 1;
            if (sel >= 96) mag = neg ? 32'd2147483648 : 32'd2147483647;
        end
        return neg ? t_value'(-mag) : t_value'(mag);
    endfunction

    task run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_number(random_value());
        drain();
    endtask

    t_value directed[$] = '{
        0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
        2147483647, 32'sh80000000, -2147483647, 2147483646, 32'sh80000000,
        1000000000, -1000000000, 999999999, -999999999, 1999999999,
        32'sh55555555, 32'shAAAAAAAA, 12345, -5, 42
    };

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.value = '0;
        out_if.ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Edges of the range, decimal boundaries and sign cases, back to back.
        foreach (directed[i]) send_number(directed[i]);
        drain();

        // Random numbers under each traffic pattern; drain between phases.
        run_phase(0, 0, 120);
        run_phase(69, 0, 120);
        run_phase(0, 69, 120);
        run_phase(30, 30, 120);

        recv_stall_pct = 0;
        repeat (20) @(posedge i_clk);
        sb.check_leftover();

        $display("converted %0d numbers (%0d negative) into %0d checked char words",
                 sb.numbers_seen, sb.negatives_seen, sb.chars_seen);
        $display("traffic: no idling, sender gaps, receiver stalls, both; %0d mismatches",
                 sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
